[rtl/pcas_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcas_pkg
// Shared constants, types and small lookup functions for the packed calendar
// add-seconds pipeline.
// ----------------------------------------------------------------------------
package pcas_pkg;

  // Field codes meaning "unset"
  localparam logic [4:0] YEAR_UNSET = 5'd31;
  localparam logic [3:0] MON_UNSET  = 4'd15;
  localparam logic [5:0] MDAY_UNSET = 6'd63;
  localparam logic [4:0] HOUR_UNSET = 5'd31;
  localparam logic [5:0] MIN_UNSET  = 6'd63;

  // Days from 1970-01-01 to 2000-01-01
  localparam logic [14:0] DAYS_2000   = 15'd10957;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;

  // floor(t / 86400) = floor(floor(t / 128) / 675); the bias keeps the
  // reciprocal operand positive (675 * 2^15)
  localparam logic [26:0] N_BIAS     = 27'd22118400;
  localparam logic [26:0] RECIP_675  = 27'd101806633;  // ceil(2^36 / 675)
  localparam logic [9:0]  DIV_675    = 10'd675;
  // quotient bias 2^15 less the offset of 1900-03-01 (-25508 days)
  localparam logic [16:0] DAY_BIAS   = 17'd7260;

  localparam logic [17:0] RECIP_1461 = 18'd183735;     // ceil(2^28 / 1461)
  localparam logic [10:0] DAYS_4YR   = 11'd1461;
  localparam logic [17:0] RECIP_7    = 18'd149797;     // ceil(2^20 / 7)
  localparam logic [15:0] RECIP_15   = 16'd34953;      // ceil(2^19 / 15)
  localparam logic [9:0]  RECIP_15S  = 10'd547;        // ceil(2^13 / 15)

  typedef struct packed {
    logic [14:0] days;   // days since 1970-01-01 of the base
    logic [16:0] hms;    // seconds into that day (may exceed one day)
    logic [32:0] delta;  // signed delta, already negated for subtract
    logic [1:0]  flags;
  } base_t;

  typedef struct packed {
    logic [16:0] nd;     // days since 1900-03-01
    logic [16:0] sod;    // second of day
    logic [1:0]  flags;
  } split_t;

  // Days before month m (0 = January) in a common year
  function automatic logic [8:0] jan_cum(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Day-of-year where month mp starts, year counted from March 1
  function automatic logic [8:0] mar_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/pcas_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcas_decode
// Input register, field unpacking and base day / second-of-day computation.
// ----------------------------------------------------------------------------
module pcas_decode
  import pcas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        op,
  input  logic [31:0] packed_time,
  input  logic [31:0] seconds_delta,
  output logic        out_valid,
  output base_t       base
);

  logic        v0;
  logic        op0;
  logic [31:0] w0;
  logic [31:0] sd0;

  logic        v1;
  base_t       base1;

  logic [4:0]  yr_f;
  logic [3:0]  mon_f;
  logic [5:0]  mday_f;
  logic [4:0]  hr_f;
  logic [5:0]  mn_f;
  logic        unset;
  logic        carry;
  logic [5:0]  yy;
  logic [3:0]  mi;
  logic        leap;
  logic [14:0] jan1;
  logic [14:0] days;
  logic [4:0]  h;
  logic [5:0]  mn;
  logic [16:0] hms;
  logic [32:0] dext;
  logic [32:0] deff;
  base_t       base_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= in_valid;
    end
    if (in_valid) begin
      op0 <= op;
      w0  <= packed_time;
      sd0 <= seconds_delta;
    end
  end

  always_comb begin
    yr_f   = w0[28:24];
    mon_f  = w0[23:20];
    mday_f = w0[19:14];
    hr_f   = w0[10:6];
    mn_f   = w0[5:0];
    unset  = (yr_f == YEAR_UNSET) || (mon_f == MON_UNSET) || (mday_f == MDAY_UNSET);

    // month 12..14 rolls into the next year
    carry = (mon_f >= 4'd12);
    yy    = {1'b0, yr_f} + 6'(carry);
    mi    = carry ? (mon_f - 4'd12) : mon_f;
    leap  = (yy[1:0] == 2'b00);   // 2000..2031: every fourth year
    jan1  = DAYS_2000 + 15'(yy) * 15'(365) + 15'((yy + 6'd3) >> 2);
    days  = jan1 + 15'(jan_cum(mi)) + 15'(leap && (mi >= 4'd2)) + 15'(mday_f);

    h   = (hr_f != HOUR_UNSET) ? hr_f : 5'd0;
    mn  = ((hr_f != HOUR_UNSET) && (mn_f != MIN_UNSET)) ? mn_f : 6'd0;
    hms = 17'(h) * 17'(3600) + 17'(mn) * 17'(60);

    dext = {sd0[31], sd0};
    deff = op0 ? (33'd0 - dext) : dext;

    base_next.days  = unset ? 15'd0 : days;
    base_next.hms   = unset ? 17'd0 : hms;
    base_next.delta = deff;
    base_next.flags = w0[30:29];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    if (v0) begin
      base1 <= base_next;
    end
  end

  assign out_valid = v1;
  assign base      = base1;

endmodule

[rtl/pcas_split.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcas_split
// Forms the shifted timestamp and splits it into a day number and a second
// of day by reciprocal multiplication (three stages).
// ----------------------------------------------------------------------------
module pcas_split
  import pcas_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  base_t  base,
  output logic   out_valid,
  output split_t split
);

  logic        v2;
  logic [33:0] t2;
  logic [1:0]  f2;

  logic        v3;
  logic [25:0] n3;
  logic [52:0] prod3;
  logic [6:0]  r1_3;
  logic [1:0]  f3;

  logic        v4;
  split_t      s4;

  logic [26:0] n27;
  logic [16:0] q;
  logic [25:0] rem;
  split_t      s4_next;

  // stage 2: t = days * 86400 + hms + delta, 34-bit two's complement
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= in_valid;
    end
    if (in_valid) begin
      t2 <= 34'(base.days) * 34'(SECS_PER_DAY) + 34'(base.hms)
          + {base.delta[32], base.delta};
      f2 <= base.flags;
    end
  end

  // stage 3: floor(t / 128) biased positive, times reciprocal of 675
  assign n27 = t2[33:7] + N_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    if (v2) begin
      n3    <= n27[25:0];
      prod3 <= 53'(n27[25:0]) * 53'(RECIP_675);
      r1_3  <= t2[6:0];
      f3    <= f2;
    end
  end

  // stage 4: quotient and remainder; second of day = rem * 128 + low bits
  always_comb begin
    q             = prod3[52:36];
    rem           = n3 - 26'(q) * 26'(DIV_675);
    s4_next.nd    = q - DAY_BIAS;
    s4_next.sod   = {rem[9:0], r1_3};
    s4_next.flags = f3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    if (v3) begin
      s4 <= s4_next;
    end
  end

  assign out_valid = v4;
  assign split     = s4;

endmodule

[rtl/pcas_civil.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcas_civil
// Day number to year / month / day / weekday and second of day to hour /
// minute, then repacking into the result register (four stages).
// ----------------------------------------------------------------------------
module pcas_civil
  import pcas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  split_t      split,
  output logic        done,
  output logic [31:0] packed_result
);

  // stage 5
  logic        v5;
  logic [16:0] nd5;
  logic [16:0] xw5;
  logic [34:0] pc5;
  logic [34:0] pw5;
  logic [30:0] pm5;
  logic [1:0]  f5;
  logic [16:0] xw;

  // stage 6
  logic        v6;
  logic [5:0]  cyc6;
  logic [10:0] c6;
  logic [2:0]  wday6;
  logic [10:0] mins6;
  logic [1:0]  f6;
  logic [5:0]  cyc;
  logic [16:0] c_full;
  logic [14:0] qw;
  logic [16:0] w_full;

  // stage 7
  logic        v7;
  logic [5:0]  cyc7;
  logic [1:0]  yoe7;
  logic [8:0]  doy7;
  logic [2:0]  wday7;
  logic [10:0] mins7;
  logic [18:0] hp7;
  logic [1:0]  f7;
  logic [1:0]  yoe;
  logic [10:0] doy_full;

  // stage 8
  logic        v8;
  logic [31:0] res8;
  logic [3:0]  mp;
  logic [5:0]  dm1;
  logic [3:0]  mon;
  logic [7:0]  year_off;
  logic [7:0]  yr_rel;
  logic [4:0]  hour;
  logic [10:0] min_full;
  logic [31:0] res_next;

  assign xw = split.nd + 17'd4;  // weekday of day n is (n + 4) mod 7

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= in_valid;
    end
    if (in_valid) begin
      nd5 <= split.nd;
      xw5 <= xw;
      pc5 <= 35'(split.nd) * 35'(RECIP_1461);
      pw5 <= 35'(xw) * 35'(RECIP_7);
      pm5 <= 31'(split.sod[16:2]) * 31'(RECIP_15);
      f5  <= split.flags;
    end
  end

  always_comb begin
    cyc    = pc5[33:28];
    c_full = nd5 - 17'(cyc) * 17'(DAYS_4YR);
    qw     = pw5[34:20];
    w_full = xw5 - 17'(qw) * 17'(7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= v5;
    end
    if (v5) begin
      cyc6  <= cyc;
      c6    <= c_full[10:0];
      wday6 <= w_full[2:0];
      mins6 <= pm5[29:19];
      f6    <= f5;
    end
  end

  // year within the four-year cycle; the leap day (offset 1460) stays in year 3
  always_comb begin
    if (c6 >= 11'd1095) begin
      yoe = 2'd3;
    end else if (c6 >= 11'd730) begin
      yoe = 2'd2;
    end else if (c6 >= 11'd365) begin
      yoe = 2'd1;
    end else begin
      yoe = 2'd0;
    end
    doy_full = c6 - 11'(yoe) * 11'(365);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
    if (v6) begin
      cyc7  <= cyc6;
      yoe7  <= yoe;
      doy7  <= doy_full[8:0];
      wday7 <= wday6;
      mins7 <= mins6;
      hp7   <= 19'(mins6[10:2]) * 19'(RECIP_15S);
      f7    <= f6;
    end
  end

  always_comb begin
    mp = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (doy7 >= mar_start(4'(i))) begin
        mp = mp + 4'd1;
      end
    end
    dm1      = 6'(doy7 - mar_start(mp));
    mon      = (mp >= 4'd10) ? (mp - 4'd10) : (mp + 4'd2);
    // years since 1900; January and February belong to the next year
    year_off = 8'(cyc7) * 8'd4 + 8'(yoe7) + 8'(mp >= 4'd10);
    yr_rel   = year_off - 8'd100;
    hour     = hp7[17:13];
    min_full = mins7 - 11'(hour) * 11'(60);
    res_next = {1'b0, f7, yr_rel[4:0], mon, dm1, wday7, hour, min_full[5:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else begin
      v8 <= v7;
    end
    if (v7) begin
      res8 <= res_next;
    end
  end

  assign done          = v8;
  assign packed_result = res8;

  a_bit31_zero: assert property (@(posedge clk) disable iff (rst)
    done |-> (packed_result[31] == 1'b0))
    else $error("result bit 31 set");

  a_month_day: assert property (@(posedge clk) disable iff (rst)
    done |-> ((packed_result[23:20] < 4'd12) && (packed_result[19:14] < 6'd31)))
    else $error("month or day out of range");

  a_wday_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (packed_result[13:11] < 3'd7))
    else $error("weekday out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((packed_result[10:6] < 5'd24) && (packed_result[5:0] < 6'd60)))
    else $error("hour or minute out of range");

endmodule

[rtl/packed_calendar_add_seconds_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_calendar_add_seconds_core
// Adds or subtracts a signed seconds delta to a packed calendar word and
// returns the normalized, repacked word.
// ----------------------------------------------------------------------------
// done pulses once an accepted item has passed through the decode, split and civil stages.
// Throughput: one item per cycle; fixed 9-register pipeline, no back-pressure.
// busy is low except during reset; results are not held for the receiver.
// Reset (rst, synchronous) clears all pipeline valid bits; items in flight
// are dropped.
module packed_calendar_add_seconds_core
  import pcas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [31:0] packed_time,
  input  logic [31:0] seconds_delta,
  output logic        done,
  output logic [31:0] packed_result
);

  logic   accept;
  logic   dec_valid;
  base_t  dec_base;
  logic   spl_valid;
  split_t spl_data;

  assign busy   = rst;
  assign accept = start && !busy;

  pcas_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (accept),
    .op            (op),
    .packed_time   (packed_time),
    .seconds_delta (seconds_delta),
    .out_valid     (dec_valid),
    .base          (dec_base)
  );

  pcas_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .base      (dec_base),
    .out_valid (spl_valid),
    .split     (spl_data)
  );

  pcas_civil u_civil (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (spl_valid),
    .split         (spl_data),
    .done          (done),
    .packed_result (packed_result)
  );

endmodule
